// ===== rtl/core/gse_pkg.sv =====
// gse_pkg: shared constants, codes and types of the gate sync engine.
// No dependencies; imported by every module of the block except gse_ram.
package gse_pkg;

  // Default sizes, handed down from the top level
  localparam int GATES_DEF   = 16;
  localparam int THREADS_DEF = 32;

  // Field widths
  localparam int FUNC_W   = 3;
  localparam int OBJ_W    = 8;
  localparam int THR_W    = 5;
  localparam int STATUS_W = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // Stream payload widths, padded to whole bytes
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;

  // Command codes
  localparam logic [FUNC_W-1:0] FUNC_ALLOC = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_FREE  = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_WAIT  = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_EXIT  = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_OPEN  = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_CLOSE = 3'd5;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_LOCKED = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NO_FREE    = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GATE_BASE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHECK_ARGS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHECK_LOCKED = 2'd2;

  // Gate state bits
  localparam int SIG_BIT  = 0;
  localparam int LOCK_BIT = 1;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;  // input transfer: latch command, start entry read
    logic commit;   // execute: write back entry, load result register
  } gse_cmd_t;

endpackage

// ===== rtl/core/gate_sync_engine_top.sv =====
// gate_sync_engine_top: gate synchronizer with per-gate wait queues.
// Depends on gse_pkg, gse_ctrl, gse_dpath (which holds gse_ram).
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------
//  in_     | slave     | in_tvalid/in_tready  | in_tdata: command
//  out_    | master    | out_tvalid/out_tready| out_tdata: result
//  cfg_    | slave     | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// For each command, the transfer cycle starts a read of the gate's entry (state
// bits and waiter bitmap) from the entry RAM; the execute state then modifies
// and writes it back and loads the result register.
// The result register decouples the sides; execute stalls only while a
// previous result is still waiting for out_tready.
// Reset (synchronous, rst_n low) clears control, config and per-gate flags;
// one valid bit per entry makes unwritten RAM entries read as all zero, so
// no clearing pass is needed. cfg_ready is always high.
module gate_sync_engine_top
  import gse_pkg::*;
#(
  parameter int GATES   = GATES_DEF,
  parameter int THREADS = THREADS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // [2:0] func, [10:3] object_id, [15:11] thread, [16] leave_open
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [1:0] status, [2] entered, [3] blocked, [4] woken_valid,
  // [9:5] woken_thread, [17:10] new_gate
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  gse_cmd_t            cmd;
  logic [STATUS_W-1:0] status;
  logic                entered, blocked, woken_valid;
  logic [THR_W-1:0]    woken_thread;
  logic [OBJ_W-1:0]    new_gate;

  assign cfg_ready = 1'b1;

  gse_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  gse_dpath #(
    .GATES   (GATES),
    .THREADS (THREADS)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_func          (in_tdata[2:0]),
    .in_object_id     (in_tdata[10:3]),
    .in_thread        (in_tdata[15:11]),
    .in_leave_open    (in_tdata[16]),
    .cfg_we           (cfg_valid & cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_status       (status),
    .out_entered      (entered),
    .out_blocked      (blocked),
    .out_woken_valid  (woken_valid),
    .out_woken_thread (woken_thread),
    .out_new_gate     (new_gate)
  );

  // pad with zeros up to the byte boundary
  assign out_tdata = {6'b0, new_gate, woken_thread, woken_valid, blocked, entered, status};

endmodule

// ===== rtl/core/gse_ram.sv =====
// gse_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module gse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/gse_ctrl.sv =====
// gse_ctrl: command sequencer of the gate sync engine.
// Depends on gse_pkg; drives gse_dpath through gse_cmd_t.
module gse_ctrl
  import gse_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  output logic     out_tvalid,
  input  logic     out_tready,
  output gse_cmd_t cmd
);

  localparam logic [0:0] S_IDLE = 1'b0;
  localparam logic [0:0] S_EXEC = 1'b1;

  logic [0:0] state_r, state_nxt;
  logic       out_tvalid_r, out_tvalid_nxt;
  logic       accept, commit;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign accept     = in_tvalid & in_tready;
  // result register must be free (or emptying) before a new result lands
  assign commit     = (state_r == S_EXEC) & (~out_tvalid_r | out_tready);

  assign cmd.capture = accept;
  assign cmd.commit  = commit;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (commit) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (commit) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

`ifndef SYNTH
  a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_EXEC) && !in_tready)
    else $error("transfer accepted but execute not entered");

  a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> out_tvalid_r)
    else $error("committed result not presented");

  a_exec_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC) && !commit |=> (state_r == S_EXEC) && out_tvalid_r)
    else $error("stalled execute lost its command or result");
`endif

endmodule

// ===== rtl/core/gse_dpath.sv =====
// gse_dpath: gate state, waiter queues, config registers and result register.
// Depends on gse_pkg and gse_ram; sequenced by gse_ctrl.
module gse_dpath
  import gse_pkg::*;
#(
  parameter int GATES   = GATES_DEF,
  parameter int THREADS = THREADS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  gse_cmd_t              cmd,
  input  logic [FUNC_W-1:0]     in_func,
  input  logic [OBJ_W-1:0]      in_object_id,
  input  logic [THR_W-1:0]      in_thread,
  input  logic                  in_leave_open,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic [STATUS_W-1:0]   out_status,
  output logic                  out_entered,
  output logic                  out_blocked,
  output logic                  out_woken_valid,
  output logic [THR_W-1:0]      out_woken_thread,
  output logic [OBJ_W-1:0]      out_new_gate
);

  localparam int GW = (GATES > 1) ? $clog2(GATES) : 1;
  localparam int TW = $clog2(THREADS);
  localparam int EW = 2 + THREADS;  // {waiters, lock, signal}

  // config
  logic [OBJ_W-1:0] gate_base_r;
  logic             check_args_r, check_locked_r;

  // per-gate flags in flops; entry valid bits stand in for RAM reset
  logic [GATES-1:0] in_use_r, in_use_nxt;
  logic [GATES-1:0] vld_r, vld_nxt;

  // latched command
  logic [FUNC_W-1:0] func_r;
  logic [OBJ_W-1:0]  g_r;
  logic [THR_W-1:0]  thr_r;
  logic              lopen_r;
  logic              found_r;
  logic [GW-1:0]     aidx_r;

  // accept-side
  logic [OBJ_W-1:0] g_in;
  logic             free_found;
  logic [GW-1:0]    free_idx;
  logic [GW-1:0]    rd_addr;
  logic [EW-1:0]    rdata;

  // execute-side
  logic [GW-1:0]        idx;
  logic                 g_ok;
  logic [EW-1:0]        ent;
  logic [1:0]           sl, new_sl, ho_sl;
  logic [THREADS-1:0]   q, new_q, wbit;
  logic                 ho_en, q_nz;
  logic [TW-1:0]        low_t;
  logic                 we;
  logic                 use_set, use_clr;
  logic [STATUS_W-1:0]  status_c;
  logic                 entered_c, blocked_c, woken_c;
  logic [OBJ_W-1:0]     new_gate_c;

  assign g_in = in_object_id - gate_base_r;

  // lowest unallocated gate
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = GATES - 1; i >= 0; i--) begin
      if (!in_use_r[i]) begin
        free_found = 1'b1;
        free_idx   = GW'(i);
      end
    end
  end

  assign rd_addr = (in_func == FUNC_ALLOC) ? free_idx : g_in[GW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r  <= in_func;
      g_r     <= g_in;
      thr_r   <= in_thread;
      lopen_r <= in_leave_open;
      found_r <= free_found;
      aidx_r  <= free_idx;
    end
  end

  gse_ram #(
    .WIDTH (EW),
    .DEPTH (GATES)
  ) u_ram (
    .clk   (clk),
    .we    (we & cmd.commit),
    .waddr (idx),
    .wdata ({new_q, new_sl}),
    .re    (cmd.capture),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  assign idx  = (func_r == FUNC_ALLOC) ? aidx_r : g_r[GW-1:0];
  assign g_ok = (g_r < OBJ_W'(GATES));
  assign ent  = vld_r[idx] ? rdata : '0;
  assign sl   = ent[1:0];
  assign q    = ent[EW-1:2];
  assign q_nz = |q;

  always_comb begin
    low_t = '0;
    for (int i = THREADS - 1; i >= 0; i--) begin
      if (q[i]) low_t = TW'(i);
    end
  end

  always_comb begin
    wbit = '0;
    wbit[thr_r[TW-1:0]] = 1'b1;
  end

  always_comb begin
    new_sl     = sl;
    new_q      = q;
    ho_en      = 1'b0;
    ho_sl      = sl;
    we         = 1'b0;
    use_set    = 1'b0;
    use_clr    = 1'b0;
    status_c   = ST_OK;
    entered_c  = 1'b0;
    blocked_c  = 1'b0;
    woken_c    = 1'b0;
    new_gate_c = '0;

    priority if (func_r == FUNC_ALLOC) begin
      if (found_r) begin
        use_set    = 1'b1;
        new_sl     = 2'b00;
        we         = 1'b1;
        new_gate_c = OBJ_W'(aidx_r) + gate_base_r;
      end else begin
        status_c = ST_NO_FREE;
      end
    end else if (func_r > FUNC_CLOSE) begin
      // unused codes: nothing
    end else if (!g_ok) begin
      if (check_args_r) status_c = ST_INVALID;
    end else if (func_r == FUNC_FREE) begin
      use_clr = 1'b1;
    end else if (check_args_r && !in_use_r[idx]) begin
      status_c = ST_INVALID;
    end else begin
      we = 1'b1;
      unique case (func_r)
        FUNC_WAIT: begin
          if (32'(thr_r) < THREADS) begin
            if (sl == 2'b01) begin
              new_sl    = 2'b10;
              entered_c = 1'b1;
            end else begin
              new_q     = q | wbit;
              blocked_c = 1'b1;
            end
          end
        end
        FUNC_EXIT: begin
          if (check_locked_r && !sl[LOCK_BIT]) begin
            status_c = ST_NOT_LOCKED;
          end else if (lopen_r) begin
            ho_en = 1'b1;
            ho_sl = sl | 2'b01;
          end else if (!sl[SIG_BIT]) begin
            new_sl = sl & 2'b01;
          end else begin
            ho_en = 1'b1;
          end
        end
        FUNC_OPEN: begin
          if (sl[LOCK_BIT]) begin
            new_sl = sl | 2'b01;
          end else begin
            ho_en = 1'b1;
            ho_sl = 2'b11;
          end
        end
        FUNC_CLOSE: new_sl = sl & 2'b10;
        default: ;
      endcase
      // hand a signaled, locked gate to the lowest waiter, or unlock it
      if (ho_en) begin
        if (!q_nz) begin
          new_sl = ho_sl & 2'b01;
        end else begin
          new_sl  = ho_sl & 2'b10;
          new_q   = q & ~(THREADS'(1) << low_t);
          woken_c = 1'b1;
        end
      end
    end
  end

  always_comb begin
    in_use_nxt = in_use_r;
    vld_nxt    = vld_r;
    if (cmd.commit) begin
      if (use_set) in_use_nxt[idx] = 1'b1;
      if (use_clr) in_use_nxt[idx] = 1'b0;
      if (we)      vld_nxt[idx]    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_use_r       <= '0;
      vld_r          <= '0;
      gate_base_r    <= '0;
      check_args_r   <= 1'b1;
      check_locked_r <= 1'b1;
    end else begin
      in_use_r <= in_use_nxt;
      vld_r    <= vld_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_GATE_BASE:    gate_base_r    <= cfg_data;
          CFG_CHECK_ARGS:   check_args_r   <= cfg_data[0];
          CFG_CHECK_LOCKED: check_locked_r <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status       <= status_c;
      out_entered      <= entered_c;
      out_blocked      <= blocked_c;
      out_woken_valid  <= woken_c;
      out_woken_thread <= woken_c ? THR_W'(low_t) : '0;
      out_new_gate     <= new_gate_c;
    end
  end

endmodule

// ===== dv/tb_gate_sync_engine_top.sv =====
// tb_gate_sync_engine_top: self-checking testbench for the gate sync engine.
// Needs gse_pkg and gate_sync_engine_top; a directed table, then random phases,
// each result checked against a typed row or a cycle-free model of the gate table.
module tb_gate_sync_engine_top;
  import gse_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int GATES_N = GATES_DEF;
  localparam int THREADS_N = THREADS_DEF;
  localparam logic [31:0] THREAD_MASK =
      (THREADS_N >= 32) ? 32'hFFFF_FFFF : ((32'd1 << THREADS_N) - 32'd1);
  localparam int SETTLE_CYCLES = 4;   // transfer and execute steps plus margin
  localparam int PHASE_ITEMS = 125;
  localparam int PHASES = 6;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [OBJ_W-1:0]  obj;
    logic [THR_W-1:0]  thr;
    logic              lopen;
  } gate_cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                entered;
    logic                blocked;
    logic                woken_valid;
    logic [THR_W-1:0]    woken_thread;
    logic [OBJ_W-1:0]    new_gate;
  } gate_res_t;

  typedef enum logic { ROW_CMD, ROW_CFG } row_kind_t;

  typedef struct {
    row_kind_t kind;
    gate_cmd_t cmd;
    logic      typed;   // 1: want holds the expected result, typed in below
    gate_res_t want;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] val;
  } stim_row_t;

  // DUT signals; the inputs are known from time zero
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Model copy of the gate table and registers
  logic [1:0]  gate_sl      [GATES_N];   // [SIG_BIT] signaled, [LOCK_BIT] locked
  logic        gate_used    [GATES_N];
  logic [31:0] gate_waiters [GATES_N];
  logic [7:0]  cfg_base = 8'd0;
  logic        chk_args = 1'b1;
  logic        chk_locked = 1'b1;

  gate_res_t pending_results[$];
  stim_row_t stim_table[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int err_count = 0;
  int cmds_sent = 0;
  int results_checked = 0;
  int wakeups_seen = 0;
  int no_free_seen = 0;

  gate_sync_engine_top dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("gate_sync_engine_top regression: fail");
    $finish;
  end

  initial begin
    for (int i = 0; i < GATES_N; i++) begin
      gate_sl[i] = 2'b00;
      gate_used[i] = 1'b0;
      gate_waiters[i] = 32'd0;
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    err_count++;
    $display("MISMATCH %s: got 0x%0h want 0x%0h at %0t", what, got, want, $realtime);
  endtask

  // Release the lowest waiter of a signaled+locked gate, or just unlock it
  function automatic void hand_over_gate(input int g, inout gate_res_t r);
    logic [31:0] q;
    int t;
    q = gate_waiters[g] & THREAD_MASK;
    if (q == 32'd0) begin
      gate_sl[g][LOCK_BIT] = 1'b0;
      return;
    end
    t = 0;
    while (!q[t]) t++;
    gate_waiters[g] = q & ~(32'd1 << t);
    gate_sl[g][SIG_BIT] = 1'b0;
    r.woken_valid = 1'b1;
    r.woken_thread = t[THR_W-1:0];
  endfunction

  // Apply one command to the model table and return the result it yields
  function automatic gate_res_t predict_gate_cmd(input gate_cmd_t c);
    gate_res_t r;
    logic [7:0] g;
    int i;
    r = '0;
    g = c.obj - cfg_base;
    if (c.func > FUNC_CLOSE) return r;
    if (c.func == FUNC_ALLOC) begin
      for (i = 0; i < GATES_N; i++) begin
        if (!gate_used[i]) begin
          gate_used[i] = 1'b1;
          gate_sl[i] = 2'b00;
          r.new_gate = 8'(i) + cfg_base;
          return r;
        end
      end
      r.status = ST_NO_FREE;
      return r;
    end
    if (int'(g) >= GATES_N) begin
      if (chk_args) r.status = ST_INVALID;
      return r;
    end
    if (c.func == FUNC_FREE) begin
      gate_used[g] = 1'b0;
      return r;
    end
    if (chk_args && !gate_used[g]) begin
      r.status = ST_INVALID;
      return r;
    end
    case (c.func)
      FUNC_WAIT: begin
        if (int'(c.thr) < THREADS_N) begin
          if (gate_sl[g][SIG_BIT] && !gate_sl[g][LOCK_BIT]) begin
            gate_sl[g] = 2'b00;
            gate_sl[g][LOCK_BIT] = 1'b1;
            r.entered = 1'b1;
          end else begin
            gate_waiters[g] = gate_waiters[g] | (32'd1 << c.thr);
            r.blocked = 1'b1;
          end
        end
      end
      FUNC_EXIT: begin
        if (chk_locked && !gate_sl[g][LOCK_BIT]) begin
          r.status = ST_NOT_LOCKED;
        end else if (c.lopen) begin
          gate_sl[g][SIG_BIT] = 1'b1;
          hand_over_gate(g, r);
        end else if (!gate_sl[g][SIG_BIT]) begin
          gate_sl[g][LOCK_BIT] = 1'b0;
        end else begin
          hand_over_gate(g, r);
        end
      end
      FUNC_OPEN: begin
        if (gate_sl[g][LOCK_BIT]) begin
          gate_sl[g][SIG_BIT] = 1'b1;
        end else begin
          gate_sl[g] = 2'b11;
          hand_over_gate(g, r);
        end
      end
      default: begin
        gate_sl[g][SIG_BIT] = 1'b0;
      end
    endcase
    return r;
  endfunction

  // Waits until every queued result has been seen, then lets the pipe settle
  task automatic wait_all_results();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write, only with the engine idle; in_tvalid must already be low
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    wait_all_results();
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_GATE_BASE:    cfg_base = val;
      CFG_CHECK_ARGS:   chk_args = val[0];
      CFG_CHECK_LOCKED: chk_locked = val[0];
      default: ;
    endcase
  endtask

  // One command transfer; the expectation is queued at the accepting edge
  task automatic send_cmd(input gate_cmd_t c, input logic typed, input gate_res_t want);
    gate_res_t r;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tdata <= {7'd0, c.lopen, c.thr, c.obj, c.func};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    r = predict_gate_cmd(c);
    pending_results.push_back(typed ? want : r);
    cmds_sent++;
  endtask

  function automatic void add_cmd_row(input logic [FUNC_W-1:0] f, input logic [OBJ_W-1:0] o,
                                      input logic [THR_W-1:0] t, input logic l,
                                      input logic typed, input gate_res_t want);
    stim_row_t row;
    row.kind = ROW_CMD;
    row.cmd = '{func: f, obj: o, thr: t, lopen: l};
    row.typed = typed;
    row.want = want;
    row.idx = '0;
    row.val = '0;
    stim_table.push_back(row);
  endfunction

  function automatic void add_cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] val);
    stim_row_t row;
    row.kind = ROW_CFG;
    row.cmd = '0;
    row.typed = 1'b0;
    row.want = '0;
    row.idx = idx;
    row.val = val;
    stim_table.push_back(row);
  endfunction

  // Mostly well-aimed commands on a few busy gates, some noise and bad ids
  function automatic gate_cmd_t random_gate_cmd();
    gate_cmd_t c;
    int r;
    int g;
    r = $urandom_range(0, 99);
    c.thr = THR_W'($urandom_range(0, 31));
    c.lopen = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 99) < 6) g = $urandom_range(GATES_N, 255);
    else if ($urandom_range(0, 99) < 60) g = $urandom_range(0, 3);
    else g = $urandom_range(0, GATES_N - 1);
    c.obj = 8'(g) + cfg_base;
    if (r < 8) begin
      c.func = FUNC_W'($urandom_range(0, 7));
      c.obj = OBJ_W'($urandom_range(0, 255));
    end else if (r < 22) begin
      c.func = FUNC_ALLOC;
      c.obj = OBJ_W'($urandom_range(0, 255));
    end else if (r < 30) c.func = FUNC_FREE;
    else if (r < 55) c.func = FUNC_WAIT;
    else if (r < 72) c.func = FUNC_EXIT;
    else if (r < 88) c.func = FUNC_OPEN;
    else c.func = FUNC_CLOSE;
    return c;
  endfunction

  // Result side: random stalls, every transfer checked field by field
  initial begin
    gate_res_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        results_checked++;
        if (pending_results.size() == 0) begin
          report_mismatch("result with nothing pending", int'(out_tdata), 0);
        end else begin
          want = pending_results.pop_front();
          if (out_tdata[1:0] != want.status)
            report_mismatch("status", out_tdata[1:0], want.status);
          if (out_tdata[2] != want.entered)
            report_mismatch("entered", out_tdata[2], want.entered);
          if (out_tdata[3] != want.blocked)
            report_mismatch("blocked", out_tdata[3], want.blocked);
          if (out_tdata[4] != want.woken_valid)
            report_mismatch("woken_valid", out_tdata[4], want.woken_valid);
          if (out_tdata[9:5] != want.woken_thread)
            report_mismatch("woken_thread", out_tdata[9:5], want.woken_thread);
          if (out_tdata[17:10] != want.new_gate)
            report_mismatch("new_gate", out_tdata[17:10], want.new_gate);
          if (want.woken_valid) wakeups_seen++;
          if (want.status == ST_NO_FREE) no_free_seen++;
        end
      end
      out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  initial begin
    gate_res_t none;
    stim_row_t row;
    int waited;
    int ph;
    int n;
    none = '0;

    // Directed table. Typed rows: reset state and error codes; rest predicted.
    add_cmd_row(3'd6, 8'hFF, 5'd31, 1'b1, 1'b1, none);            // unused code
    add_cmd_row(3'd7, 8'h00, 5'd0, 1'b0, 1'b1, none);             // unused code
    add_cmd_row(FUNC_WAIT, 8'h00, 5'd0, 1'b0, 1'b1,
                {ST_INVALID, 1'b0, 1'b0, 1'b0, 5'd0, 8'd0});      // not allocated
    add_cmd_row(FUNC_ALLOC, 8'hFF, 5'd0, 1'b0, 1'b1,
                {ST_OK, 1'b0, 1'b0, 1'b0, 5'd0, 8'd0});           // lowest gate
    add_cmd_row(FUNC_ALLOC, 8'h00, 5'd0, 1'b0, 1'b1,
                {ST_OK, 1'b0, 1'b0, 1'b0, 5'd0, 8'd1});
    add_cmd_row(FUNC_EXIT, 8'h00, 5'd0, 1'b0, 1'b1,
                {ST_NOT_LOCKED, 1'b0, 1'b0, 1'b0, 5'd0, 8'd0});   // exit unlocked
    add_cmd_row(FUNC_OPEN, 8'h00, 5'd0, 1'b0, 1'b0, none);        // nobody waits
    add_cmd_row(FUNC_WAIT, 8'h00, 5'd31, 1'b0, 1'b0, none);       // enters, locks
    add_cmd_row(FUNC_WAIT, 8'h00, 5'd0, 1'b0, 1'b0, none);        // queued
    add_cmd_row(FUNC_WAIT, 8'h00, 5'd5, 1'b1, 1'b0, none);        // queued
    add_cmd_row(FUNC_OPEN, 8'h00, 5'd0, 1'b0, 1'b0, none);        // locked: signal only
    add_cmd_row(FUNC_WAIT, 8'h00, 5'd7, 1'b0, 1'b0, none);        // signaled+locked
    add_cmd_row(FUNC_EXIT, 8'h00, 5'd0, 1'b0, 1'b0, none);        // wakes lowest
    add_cmd_row(FUNC_EXIT, 8'h00, 5'd0, 1'b1, 1'b0, none);        // leave open
    add_cmd_row(FUNC_CLOSE, 8'h00, 5'd0, 1'b0, 1'b0, none);
    add_cmd_row(FUNC_EXIT, 8'h00, 5'd0, 1'b0, 1'b0, none);        // closed: unlock
    add_cmd_row(FUNC_FREE, 8'h00, 5'd0, 1'b0, 1'b0, none);
    add_cmd_row(FUNC_FREE, 8'hFF, 5'd0, 1'b0, 1'b1,
                {ST_INVALID, 1'b0, 1'b0, 1'b0, 5'd0, 8'd0});      // out of range
    add_cmd_row(FUNC_OPEN, 8'd16, 5'd0, 1'b0, 1'b1,
                {ST_INVALID, 1'b0, 1'b0, 1'b0, 5'd0, 8'd0});
    add_cmd_row(FUNC_FREE, 8'h01, 5'd0, 1'b0, 1'b0, none);
    add_cfg_row(CFG_CHECK_ARGS, 8'd0);
    add_cmd_row(FUNC_OPEN, 8'd200, 5'd3, 1'b0, 1'b1, none);       // ignored silently
    add_cmd_row(FUNC_WAIT, 8'h03, 5'd2, 1'b0, 1'b0, none);        // unallocated acts
    add_cfg_row(CFG_CHECK_LOCKED, 8'd0);
    add_cmd_row(FUNC_EXIT, 8'h03, 5'd0, 1'b0, 1'b0, none);        // unlocked, proceeds
    add_cmd_row(FUNC_EXIT, 8'h03, 5'd0, 1'b1, 1'b0, none);
    add_cfg_row(CFG_GATE_BASE, 8'hFF);
    add_cmd_row(FUNC_ALLOC, 8'h00, 5'd0, 1'b0, 1'b0, none);       // base wraps
    add_cmd_row(FUNC_WAIT, 8'h00, 5'd31, 1'b1, 1'b0, none);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 10;
    recv_idle_pct = 10;
    foreach (stim_table[i]) begin
      row = stim_table[i];
      if (row.kind == ROW_CFG) begin
        in_tvalid <= 1'b0;
        write_reg(row.idx, row.val);
      end else begin
        send_cmd(row.cmd, row.typed, row.want);
      end
    end

    // Random phases: the config covers both base extremes and every flag pair
    for (ph = 0; ph < PHASES; ph++) begin
      in_tvalid <= 1'b0;
      case (ph)
        0: write_reg(CFG_GATE_BASE, 8'h00);
        1: write_reg(CFG_GATE_BASE, 8'hFF);
        4: write_reg(CFG_GATE_BASE, 8'h00);
        default: write_reg(CFG_GATE_BASE, 8'($urandom_range(1, 254)));
      endcase
      write_reg(CFG_CHECK_ARGS, (ph == 2 || ph == 4) ? 8'd0 : 8'd1);
      write_reg(CFG_CHECK_LOCKED, (ph == 2 || ph == 3) ? 8'd0 : 8'd1);
      if (ph < 2) begin
        send_idle_pct = 25;
        recv_idle_pct = 88;
      end else if (ph < 4) begin
        send_idle_pct = 88;
        recv_idle_pct = 25;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (n == PHASE_ITEMS / 2) begin
          // sender holds off until the engine has drained
          in_tvalid <= 1'b0;
          wait_all_results();
        end
        send_cmd(random_gate_cmd(), 1'b0, none);
      end
    end
    in_tvalid <= 1'b0;

    waited = 0;
    while (pending_results.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    if (pending_results.size() != 0)
      report_mismatch("results never delivered", pending_results.size(), 0);
    repeat (SETTLE_CYCLES * 2) @(posedge clk);

    $display("Covered %0d commands, %0d results, %0d wakeups, %0d no-free allocs,",
             cmds_sent, results_checked, wakeups_seen, no_free_seen);
    $display("over %0d config phases with stalls on both sides; %0d mismatches.",
             PHASES + 1, err_count);
    if (err_count == 0) begin
      $display("gate_sync_engine_top regression: pass");
    end else begin
      $display("gate_sync_engine_top regression: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/gse_pkg.sv
rtl/core/gse_ram.sv
rtl/core/gse_ctrl.sv
rtl/core/gse_dpath.sv
rtl/core/gate_sync_engine_top.sv
dv/tb_gate_sync_engine_top.sv
